/* sv/iirdf2_pkg.sv */
// Package for the direct form II IIR filter unit: widths, payload types,
// register indices, controller state and command types, rounding helpers.
// No dependencies.
package iirdf2_pkg;

  localparam int unsigned MaxOrderDefault = 3;
  localparam int unsigned SampleW         = 24;
  localparam int unsigned CoefW           = 32;
  localparam int unsigned HistW           = 32;
  localparam int unsigned AccW            = 64;
  localparam int unsigned OrderW          = 2;
  localparam int unsigned RegIdxW         = 4;
  localparam int unsigned FracShift       = 23;
  localparam int unsigned ProdShift       = 3;
  localparam int unsigned RoundW          = AccW - FracShift;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [HistW-1:0]   hist_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic signed [RoundW-1:0]  round_t;
  typedef logic [RegIdxW-1:0]        reg_idx_t;
  typedef logic [OrderW-1:0]         order_t;

  localparam reg_idx_t RegFilterOrder   = RegIdxW'(0);
  localparam reg_idx_t RegFeedCoef0     = RegIdxW'(1);
  localparam reg_idx_t RegFeedCoef1     = RegIdxW'(2);
  localparam reg_idx_t RegFeedCoef2     = RegIdxW'(3);
  localparam reg_idx_t RegFeedCoef3     = RegIdxW'(4);
  localparam reg_idx_t RegFeedbackCoef1 = RegIdxW'(5);
  localparam reg_idx_t RegFeedbackCoef2 = RegIdxW'(6);
  localparam reg_idx_t RegFeedbackCoef3 = RegIdxW'(7);

  localparam order_t FilterOrderReset = OrderW'(2);
  localparam coef_t  FeedCoef0Reset   = CoefW'(67108864);

  typedef struct packed {
    order_t filter_order;
    coef_t  feed_0;
    coef_t  feed_1;
    coef_t  feed_2;
    coef_t  feed_3;
    coef_t  feedback_1;
    coef_t  feedback_2;
    coef_t  feedback_3;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPS,
    ST_VCALC,
    ST_B0,
    ST_YDRAIN,
    ST_YOUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_FB,
    MUL_FF,
    MUL_B0
  } mul_kind_e;

  typedef struct packed {
    logic      load;
    logic      issue;
    mul_kind_e kind;
    order_t    tap;
    logic      v_calc;
    logic      y_calc;
    order_t    order_n;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // Round half up from Q.23 to Q.0.
  function automatic round_t round_q23(input acc_t a);
    acc_t t;
    t = a + (acc_t'(1) <<< (FracShift - 1));
    return t[AccW-1:FracShift];
  endfunction

  function automatic logic hist_clips(input round_t r);
    return !((&r[RoundW-1:HistW-1]) || !(|r[RoundW-1:HistW-1]));
  endfunction

  function automatic hist_t hist_sat(input round_t r);
    if (!hist_clips(r)) begin
      return r[HistW-1:0];
    end
    return r[RoundW-1] ? {1'b1, {(HistW-1){1'b0}}} : {1'b0, {(HistW-1){1'b1}}};
  endfunction

  function automatic logic sample_clips(input round_t r);
    return !((&r[RoundW-1:SampleW-1]) || !(|r[RoundW-1:SampleW-1]));
  endfunction

  function automatic sample_t sample_sat(input round_t r);
    if (!sample_clips(r)) begin
      return r[SampleW-1:0];
    end
    return r[RoundW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
  endfunction

endpackage

/* sv/iirdf2_if.sv */
// Handshake interfaces of the IIR filter unit: sample input, sample output
// and configuration write channels. Depends on iirdf2_pkg.
interface iirdf2_sample_in_if;
  logic                valid;
  logic                ready;
  iirdf2_pkg::sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface iirdf2_sample_out_if;
  logic                valid;
  logic                ready;
  iirdf2_pkg::sample_t sample_out;
  logic                saturated;
  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

interface iirdf2_cfg_if;
  logic                 valid;
  logic                 ready;
  iirdf2_pkg::reg_idx_t reg_index;
  iirdf2_pkg::coef_t    wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* sv/iirdf2_cfg_regs.sv */
// Configuration register file of the IIR filter unit: filter order and the
// feedforward and feedback coefficients. Depends on iirdf2_pkg.
module iirdf2_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  input  iirdf2_pkg::reg_idx_t wr_index_i,
  input  iirdf2_pkg::coef_t    wr_data_i,
  output iirdf2_pkg::cfg_t     cfg_o
);
  import iirdf2_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        RegFilterOrder:   cfg_d.filter_order = wr_data_i[OrderW-1:0];
        RegFeedCoef0:     cfg_d.feed_0       = wr_data_i;
        RegFeedCoef1:     cfg_d.feed_1       = wr_data_i;
        RegFeedCoef2:     cfg_d.feed_2       = wr_data_i;
        RegFeedCoef3:     cfg_d.feed_3       = wr_data_i;
        RegFeedbackCoef1: cfg_d.feedback_1   = wr_data_i;
        RegFeedbackCoef2: cfg_d.feedback_2   = wr_data_i;
        RegFeedbackCoef3: cfg_d.feedback_3   = wr_data_i;
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{filter_order: FilterOrderReset, feed_0: FeedCoef0Reset, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/iirdf2_ctrl.sv */
// Controller of the IIR filter unit: sequences the shared multiplier over
// the history taps and the output stage. Depends on iirdf2_pkg.
module iirdf2_ctrl #(
  parameter int unsigned MAX_ORDER = iirdf2_pkg::MaxOrderDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iirdf2_pkg::order_t     filter_order_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   out_ready_i,
  input  iirdf2_pkg::dp_status_t status_i,
  output iirdf2_pkg::dp_cmd_t    cmd_o
);
  import iirdf2_pkg::*;

  localparam int unsigned StepW = (MAX_ORDER > 1) ? $clog2(2 * MAX_ORDER) : 1;
  localparam int unsigned CmpW  = StepW + OrderW;

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  order_t             order_n;
  logic [CmpW-1:0]    step_ext;
  logic [CmpW-1:0]    n_ext;
  logic               step_is_fb;
  logic               step_last;

  assign order_n    = (filter_order_i > OrderW'(MAX_ORDER)) ? OrderW'(MAX_ORDER)
                                                            : filter_order_i;
  assign step_ext   = CmpW'(step_q);
  assign n_ext      = CmpW'(order_n);
  assign step_is_fb = step_ext < n_ext;
  assign step_last  = (step_ext + CmpW'(1)) == (n_ext << 1);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = (order_n == '0) ? ST_VCALC : ST_TAPS;
        end
      end
      ST_TAPS: begin
        if (step_last) begin
          state_d = ST_VCALC;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_VCALC:  state_d = ST_B0;
      ST_B0:     state_d = ST_YDRAIN;
      ST_YDRAIN: state_d = ST_YOUT;
      ST_YOUT: begin
        if (!status_i.out_full || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.kind    = MUL_FB;
    cmd_o.order_n = order_n;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_TAPS: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = step_is_fb ? MUL_FB : MUL_FF;
        cmd_o.tap   = step_is_fb ? OrderW'(step_ext) : OrderW'(step_ext - n_ext);
      end
      ST_VCALC: cmd_o.v_calc = 1'b1;
      ST_B0: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = MUL_B0;
      end
      ST_YDRAIN: cmd_o.issue = 1'b0;
      ST_YOUT:   cmd_o.y_calc = !status_i.out_full || out_ready_i;
      default:   cmd_o.issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

/* sv/iirdf2_datapath.sv */
// Datapath of the IIR filter unit: history line, shared multiplier, the two
// accumulators, rounding and saturation, output register. Depends on iirdf2_pkg.
module iirdf2_datapath #(
  parameter int unsigned MAX_ORDER = iirdf2_pkg::MaxOrderDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iirdf2_pkg::cfg_t       cfg_i,
  input  iirdf2_pkg::dp_cmd_t    cmd_i,
  output iirdf2_pkg::dp_status_t status_o,
  input  iirdf2_pkg::sample_t    sample_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output iirdf2_pkg::sample_t    sample_out_o,
  output logic                   saturated_o
);
  import iirdf2_pkg::*;

  hist_t     hist_q [MAX_ORDER];
  hist_t     v_q;
  logic      vsat_q;
  acc_t      vacc_q;
  acc_t      yacc_q;
  acc_t      prod_q;
  logic      prod_vld_q;
  mul_kind_e prod_kind_q;
  logic      out_valid_q;
  sample_t   sample_out_q;
  logic      saturated_q;
  hist_t     op_a;
  coef_t     op_b;
  hist_t     hist_rd;
  round_t    v_round;
  round_t    y_round;

  always_comb begin
    hist_rd = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (cmd_i.tap == OrderW'(i)) begin
        hist_rd = hist_q[i];
      end
    end
  end

  always_comb begin
    op_a = (cmd_i.kind == MUL_B0) ? v_q : hist_rd;
    op_b = cfg_i.feed_0;
    unique case (cmd_i.kind)
      MUL_FB: begin
        unique case (cmd_i.tap)
          2'd0:    op_b = cfg_i.feedback_1;
          2'd1:    op_b = cfg_i.feedback_2;
          default: op_b = cfg_i.feedback_3;
        endcase
      end
      MUL_FF: begin
        unique case (cmd_i.tap)
          2'd0:    op_b = cfg_i.feed_1;
          2'd1:    op_b = cfg_i.feed_2;
          default: op_b = cfg_i.feed_3;
        endcase
      end
      default: op_b = cfg_i.feed_0;
    endcase
  end

  assign v_round = round_q23(vacc_q);
  assign y_round = round_q23(yacc_q);

  always_ff @(posedge clk_i) begin
    prod_q      <= acc_t'(op_a) * acc_t'(op_b);
    prod_kind_q <= cmd_i.kind;
    if (cmd_i.load) begin
      vacc_q <= acc_t'(sample_in_i) <<< FracShift;
      yacc_q <= '0;
    end else if (prod_vld_q) begin
      if (prod_kind_q == MUL_FB) begin
        vacc_q <= vacc_q - (prod_q >>> ProdShift);
      end else begin
        yacc_q <= yacc_q + (prod_q >>> ProdShift);
      end
    end
    if (cmd_i.v_calc) begin
      v_q    <= hist_sat(v_round);
      vsat_q <= hist_clips(v_round);
    end
    if (cmd_i.y_calc) begin
      sample_out_q <= sample_sat(y_round);
      saturated_q  <= vsat_q | sample_clips(y_round);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      prod_vld_q <= cmd_i.issue;
      if (cmd_i.y_calc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.v_calc) begin
        hist_q[0] <= hist_sat(v_round);
        for (int i = 1; i < MAX_ORDER; i++) begin
          if (OrderW'(i) < cmd_i.order_n) begin
            hist_q[i] <= hist_q[i-1];
          end
        end
      end
    end
  end

  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = sample_out_q;
  assign saturated_o       = saturated_q;

endmodule

/* sv/iir_direct_form2_filter_unit.sv */
// Top level of the direct form II IIR filter unit, order up to MAX_ORDER.
// Depends on iirdf2_pkg, the interfaces, iirdf2_cfg_regs, iirdf2_ctrl and
// iirdf2_datapath.
//
//   Channel        Direction  Payload                    Transfer when
//   cfg_if         in         reg_index[3:0], wdata[31:0] valid && ready (ready is high)
//   sample_in_if   in         sample_in[23:0]            valid && ready
//   sample_out_if  out        sample_out[23:0], saturated valid && ready
//
// Each sample is worked through by the single shared 32x32 multiplier,
// which serves each feedback and feedforward tap of the active order n in
// turn, followed by the b0 product. A result sits in an output register, so
// the next sample runs while the previous result waits; the unit only stalls
// at its final step when that register is still full. Reset clears the
// history line and loads the register reset values.
module iir_direct_form2_filter_unit #(
  parameter int unsigned MAX_ORDER = iirdf2_pkg::MaxOrderDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  iirdf2_cfg_if.sink           cfg_if,
  iirdf2_sample_in_if.sink     sample_in_if,
  iirdf2_sample_out_if.source  sample_out_if
);
  import iirdf2_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_if.ready = 1'b1;

  iirdf2_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_if.valid),
    .wr_index_i (cfg_if.reg_index),
    .wr_data_i  (cfg_if.wdata),
    .cfg_o      (cfg)
  );

  iirdf2_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .filter_order_i (cfg.filter_order),
    .in_valid_i     (sample_in_if.valid),
    .in_ready_o     (sample_in_if.ready),
    .out_ready_i    (sample_out_if.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  iirdf2_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_if.sample_in),
    .out_valid_o  (sample_out_if.valid),
    .out_ready_i  (sample_out_if.ready),
    .sample_out_o (sample_out_if.sample_out),
    .saturated_o  (sample_out_if.saturated)
  );

endmodule

/* verif/tb_iir_direct_form2_filter_unit.sv */
// Self-checking testbench for iir_direct_form2_filter_unit: a directed table,
// then random phases; checked rows match the table, others a fixed-point predictor.
// Depends on iirdf2_pkg, the channel interfaces in iirdf2_if.sv and the unit itself.
module tb_iir_direct_form2_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import iirdf2_pkg::*;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_CHECKED
  } row_kind_e;

  typedef enum logic [1:0] {
    COEF_GENTLE,
    COEF_WILD,
    COEF_EDGE
  } coef_mode_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_t    idx;
    logic [31:0] wdata;
    sample_t     x;
    sample_t     y;
    logic        sat;
  } dir_row_t;

  typedef struct packed {
    sample_t y;
    logic    sat;
  } filt_out_t;

  localparam int unsigned NumDirRows    = 38;
  localparam int unsigned NumPhases     = 20;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned HoldPhase     = 3;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 2 * MaxOrderDefault + 13;
  localparam int unsigned StallLimit    = 4000;

  localparam reg_idx_t RegUnusedLow  = RegIdxW'(8);
  localparam reg_idx_t RegUnusedHigh = RegIdxW'(15);

  localparam logic [31:0] CoefMax      = 32'h7FFF_FFFF;
  localparam logic [31:0] CoefMin      = 32'h8000_0000;
  localparam logic [31:0] CoefOne      = 32'h0400_0000;
  localparam logic [31:0] CoefMinusOne = 32'hFC00_0000;
  localparam sample_t     SampMax      = 24'h7F_FFFF;
  localparam sample_t     SampMin      = 24'h80_0000;

  localparam acc_t HistLo = -64'sd2147483648;
  localparam acc_t HistHi = 64'sd2147483647;
  localparam acc_t SampLo = -64'sd8388608;
  localparam acc_t SampHi = 64'sd8388607;

  localparam dir_row_t DirTable [NumDirRows] = '{
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h7F_FFFF, 1'b0},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h80_0000, 24'h80_0000, 1'b0},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h00_0001, 24'h00_0001, 1'b0},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'hFF_FFFF, 24'hFF_FFFF, 1'b0},
    '{ROW_WRITE,   RegFeedCoef0,     CoefMax,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h7F_FFFF, 1'b1},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h80_0000, 24'h80_0000, 1'b1},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedCoef0,     CoefMin,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h80_0000, 1'b1},
    '{ROW_CHECKED, RegFilterOrder,   32'h0,        24'h80_0000, 24'h7F_FFFF, 1'b1},
    '{ROW_WRITE,   RegFeedCoef0,     CoefOne,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFilterOrder,   32'h1,        24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedbackCoef1, CoefMin,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedbackCoef1, CoefMax,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFilterOrder,   32'hFFFF_FFFF, 24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedCoef1,     CoefMax,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedCoef2,     CoefMin,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedCoef3,     32'h1234_5678, 24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedbackCoef2, CoefMin,      24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFeedbackCoef3, 32'h0000_0001, 24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h80_0000, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h55_5555, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegFilterOrder,   32'hFFFF_FFFC, 24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h2A_AAAA, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'hFF_FFFF, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h7F_FFFF, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegUnusedLow,     32'hFFFF_FFFF, 24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_WRITE,   RegUnusedHigh,    32'h0,        24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h00_0000, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE,  RegFilterOrder,   32'h0,        24'h12_3456, 24'h00_0000, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  iirdf2_cfg_if        cfg_bus ();
  iirdf2_sample_in_if  sin_bus ();
  iirdf2_sample_out_if sout_bus ();

  iir_direct_form2_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_if        (cfg_bus),
    .sample_in_if  (sin_bus),
    .sample_out_if (sout_bus)
  );

  order_t filt_order;
  coef_t  ff_coef [4];
  coef_t  fb_coef [1:3];
  hist_t  hist_line [3];

  filt_out_t   pending_out [$];
  filt_out_t   got_out;
  filt_out_t   want_out;
  int unsigned err_cnt   = 0;
  int unsigned stall_cnt = 0;
  logic        no_idle   = 1'b0;
  logic        hold_req  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    if (err_cnt < 10) begin
      $display("%s", msg);
    end
    err_cnt++;
  endtask

  function automatic filt_out_t filter_sample(input sample_t x);
    acc_t      vacc;
    acc_t      yacc;
    acc_t      rnd;
    hist_t     v;
    filt_out_t res;
    int        n;
    n = int'(filt_order);
    res.sat = 1'b0;
    vacc = acc_t'(x);
    vacc = vacc <<< FracShift;
    yacc = '0;
    for (int i = 1; i <= n; i++) begin
      vacc = vacc - ((acc_t'(hist_line[i-1]) * acc_t'(fb_coef[i])) >>> ProdShift);
      yacc = yacc + ((acc_t'(hist_line[i-1]) * acc_t'(ff_coef[i])) >>> ProdShift);
    end
    rnd = (vacc + (acc_t'(1) <<< (FracShift - 1))) >>> FracShift;
    if (rnd < HistLo) begin
      v = hist_t'(HistLo);
      res.sat = 1'b1;
    end else if (rnd > HistHi) begin
      v = hist_t'(HistHi);
      res.sat = 1'b1;
    end else begin
      v = hist_t'(rnd);
    end
    for (int i = n; i >= 2; i--) begin
      hist_line[i-1] = hist_line[i-2];
    end
    hist_line[0] = v;
    yacc = yacc + ((acc_t'(v) * acc_t'(ff_coef[0])) >>> ProdShift);
    rnd = (yacc + (acc_t'(1) <<< (FracShift - 1))) >>> FracShift;
    if (rnd < SampLo) begin
      res.y = SampMin;
      res.sat = 1'b1;
    end else if (rnd > SampHi) begin
      res.y = SampMax;
      res.sat = 1'b1;
    end else begin
      res.y = sample_t'(rnd);
    end
    return res;
  endfunction

  function automatic void apply_reg(input reg_idx_t idx, input logic [31:0] data);
    case (idx)
      RegFilterOrder:   filt_order = data[OrderW-1:0];
      RegFeedCoef0:     ff_coef[0] = data;
      RegFeedCoef1:     ff_coef[1] = data;
      RegFeedCoef2:     ff_coef[2] = data;
      RegFeedCoef3:     ff_coef[3] = data;
      RegFeedbackCoef1: fb_coef[1] = data;
      RegFeedbackCoef2: fb_coef[2] = data;
      RegFeedbackCoef3: fb_coef[3] = data;
      default: ;
    endcase
  endfunction

  function automatic sample_t pick_sample();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(9))
      0: return SampMax;
      1: return SampMin;
      2, 3: return sample_t'(int'($urandom_range(2047)) - 1024);
      default: return raw[SampleW-1:0];
    endcase
  endfunction

  function automatic coef_t pick_coef(input coef_mode_e mode, input logic feedback);
    int span;
    span = feedback ? (1 << 25) : (1 << 26);
    case (mode)
      COEF_GENTLE: return coef_t'(int'($urandom_range(2 * span)) - span);
      COEF_EDGE: begin
        case ($urandom_range(4))
          0: return CoefMax;
          1: return CoefMin;
          2: return '0;
          3: return CoefOne;
          default: return CoefMinusOne;
        endcase
      end
      default: return coef_t'($urandom());
    endcase
  endfunction

  // Entered and left at a falling edge; valid is left high for the caller.
  task automatic put_sample(input sample_t x, input logic typed, input filt_out_t typed_out);
    filt_out_t want;
    while (!no_idle && $urandom_range(99) < 8) begin
      sin_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    sin_bus.sample_in <= x;
    sin_bus.valid     <= 1'b1;
    do @(posedge clk_i); while (!sin_bus.ready);
    want = filter_sample(x);
    pending_out.push_back(typed ? typed_out : want);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    cfg_bus.valid     <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    sin_bus.valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    sout_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        sout_bus.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      sout_bus.ready <= no_idle || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sout_bus.valid && sout_bus.ready) begin
      got_out = '{sout_bus.sample_out, sout_bus.saturated};
      if (pending_out.size() == 0) begin
        flag_error($sformatf("unexpected result: sample_out %0d saturated %0b",
                             got_out.y, got_out.sat));
      end else begin
        want_out = pending_out.pop_front();
        if (got_out.y !== want_out.y || got_out.sat !== want_out.sat) begin
          flag_error($sformatf("mismatch: expected sample_out %0d saturated %0b, got %0d %0b",
                               want_out.y, want_out.sat, got_out.y, got_out.sat));
        end
      end
    end
  end

  initial begin
    while (stall_cnt < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (sin_bus.valid && sin_bus.ready) || (sout_bus.valid && sout_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", StallLimit);
    $display("tb: failure");
    $finish;
  end

  initial begin
    dir_row_t   row;
    coef_mode_e mode;
    rst_ni            = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = '0;
    cfg_bus.wdata     = '0;
    sin_bus.valid     = 1'b0;
    sin_bus.sample_in = '0;
    filt_order = FilterOrderReset;
    ff_coef    = '{FeedCoef0Reset, '0, '0, '0};
    fb_coef    = '{'0, '0, '0};
    hist_line  = '{'0, '0, '0};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      row = DirTable[r];
      case (row.kind)
        ROW_WRITE: begin
          settle();
          write_reg(row.idx, row.wdata);
        end
        ROW_CHECKED: put_sample(row.x, 1'b1, '{row.y, row.sat});
        default: put_sample(row.x, 1'b0, '0);
      endcase
    end

    for (int p = 0; p < NumPhases; p++) begin
      mode = coef_mode_e'(p % 3);
      settle();
      write_reg(RegFilterOrder, ($urandom() & ~32'd3) | 32'(p % 4));
      write_reg(RegFeedCoef0, pick_coef(mode, 1'b0));
      write_reg(RegFeedCoef1, pick_coef(mode, 1'b0));
      write_reg(RegFeedCoef2, pick_coef(mode, 1'b0));
      write_reg(RegFeedCoef3, pick_coef(mode, 1'b0));
      write_reg(RegFeedbackCoef1, pick_coef(mode, 1'b1));
      write_reg(RegFeedbackCoef2, pick_coef(mode, 1'b1));
      write_reg(RegFeedbackCoef3, pick_coef(mode, 1'b1));
      if ($urandom_range(3) == 0) begin
        write_reg(reg_idx_t'($urandom_range(RegUnusedLow, RegUnusedHigh)), $urandom());
      end
      no_idle = (p >= 6 && p < 10);
      if (p == HoldPhase) begin
        hold_req = 1'b1;
      end
      for (int k = 0; k < ItemsPerPhase; k++) begin
        put_sample(pick_sample(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    settle();
    if (pending_out.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_out.size()));
    end
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/iirdf2_pkg.sv
sv/iirdf2_if.sv
sv/iirdf2_cfg_regs.sv
sv/iirdf2_ctrl.sv
sv/iirdf2_datapath.sv
sv/iir_direct_form2_filter_unit.sv
verif/tb_iir_direct_form2_filter_unit.sv
